>>> sv/sdpt_pkg.sv
package sdpt_pkg;

  localparam int FIELD_W    = 32;
  localparam int DT_W       = 16;
  localparam int GAIN_W     = 16;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MAX_AXES   = 3;
  localparam int COEF_W     = 32;

  localparam int SPD_LSB    = FIELD_W * MAX_AXES;
  localparam int DT_LSB     = 2 * FIELD_W * MAX_AXES;
  localparam int IN_DATA_W  = DT_LSB + DT_W;
  localparam int VEL_LSB    = FIELD_W * MAX_AXES;
  localparam int OUT_DATA_W = 2 * FIELD_W * MAX_AXES;

  localparam logic [REQ_W-1:0] REQ_UPDATE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INIT    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_IMPULSE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPRING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINEAR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 2'd3;

  localparam logic [GAIN_W-1:0] SPRING_RST  = 16'd7680;
  localparam logic [GAIN_W-1:0] DAMPING_RST = 16'd2804;

  localparam int DT_SHIFT   = 17;
  localparam int GAIN_SHIFT = 24;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_KS,
    ST_KD,
    ST_P1,
    ST_V1,
    ST_V2,
    ST_P2,
    ST_DONE
  } trk_state_t;

  typedef enum logic [2:0] {
    MP_IDLE,
    MP_ABS,
    MP_LO,
    MP_HI,
    MP_RND,
    MP_ACC
  } mac_phase_t;

  typedef struct packed {
    logic start;
    logic gain_scale;
  } mac_cmd_t;

  function automatic logic is_op(input trk_state_t s);
    return (s == ST_KS) || (s == ST_KD) || (s == ST_P1) || (s == ST_V1) ||
           (s == ST_V2) || (s == ST_P2);
  endfunction

endpackage

>>> sv/spring_damper_position_tracker.sv
// Spring-damper position tracker. Keeps a virtual point per axis (signed Q16.16
// position and velocity) that a spring pulls toward the target and a damper
// drags toward the target speed, one modified-midpoint step per update beat.
// One request is taken at a time and each returns one beat with the stored
// state. Every product goes through one shared 32x32 multiply-round-saturate
// unit, whose operations step through ABS, LO, RND and ACC (plus HI when
// VALUE_WIDTH exceeds 32, where the wide operand is multiplied in two halves).
// An update runs 2 + 4*AXES such operations before DONE; init and impulse
// requests pass through LOAD to DONE, ignored ones go straight to DONE. The
// result register frees the sequencer once the beat is taken or it is empty.
module spring_damper_position_tracker
  import sdpt_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int AXES        = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // target_x, target_y, target_z, speed_x, speed_y, speed_z, time_step
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type
  input  logic [REQ_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int MW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
  localparam int EW = MW + 1;
  localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam logic signed [EW-1:0] VMAX =
    EW'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] VMIN = -VMAX - EW'(1);

  trk_state_t                    state_r, state_nxt;
  logic        [AW-1:0]          ax_r;
  logic                          start_r, start_nxt;
  logic                          out_valid_r;
  logic        [OUT_DATA_W-1:0]  out_data_r;
  logic        [OUT_DATA_W-1:0]  out_data_nxt;
  logic                          out_load;
  logic        [GAIN_W-1:0]      spring_r;
  logic        [GAIN_W-1:0]      damping_r;
  logic                          linear_r;
  logic                          active_r;

  logic signed [VALUE_WIDTH-1:0] pos_r [AXES];
  logic signed [VALUE_WIDTH-1:0] vel_r [AXES];
  logic signed [FIELD_W-1:0]     tgt_r [AXES];
  logic signed [FIELD_W-1:0]     spd_r [AXES];
  logic        [DT_W-1:0]        dt_r;
  logic        [REQ_W-1:0]       req_r;
  logic        [COEF_W-1:0]      ks_r;
  logic        [COEF_W-1:0]      kd_r;
  logic signed [VALUE_WIDTH-1:0] p1_r;

  logic                          in_acc;
  logic                          last_ax;
  mac_cmd_t                      mac_cmd;
  logic signed [MW-1:0]          mac_opa;
  logic signed [MW-1:0]          mac_opb;
  logic        [COEF_W-1:0]      mac_coef;
  logic signed [VALUE_WIDTH-1:0] mac_base;
  logic                          mac_done;
  logic signed [VALUE_WIDTH-1:0] mac_res;
  logic        [COEF_W-1:0]      mac_raw;

  function automatic logic signed [VALUE_WIDTH-1:0] sat_v(input logic signed [EW-1:0] x);
    logic signed [VALUE_WIDTH-1:0] r;
    if (x > VMAX) begin
      r = VMAX[VALUE_WIDTH-1:0];
    end else if (x < VMIN) begin
      r = VMIN[VALUE_WIDTH-1:0];
    end else begin
      r = x[VALUE_WIDTH-1:0];
    end
    return r;
  endfunction

  assign in_acc  = in_tvalid && in_tready;
  assign last_ax = (ax_r == AW'(AXES - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!(linear_r && active_r)) begin
            state_nxt = ST_DONE;
          end else begin
            unique case (in_tuser) inside
              REQ_UPDATE:            state_nxt = ST_KS;
              REQ_INIT, REQ_IMPULSE: state_nxt = ST_LOAD;
              default:               state_nxt = ST_DONE;
            endcase
          end
        end
      end
      ST_LOAD: state_nxt = ST_DONE;
      ST_KS:   if (mac_done) state_nxt = ST_KD;
      ST_KD:   if (mac_done) state_nxt = ST_P1;
      ST_P1:   if (mac_done) state_nxt = ST_V1;
      ST_V1:   if (mac_done) state_nxt = ST_V2;
      ST_V2:   if (mac_done) state_nxt = ST_P2;
      ST_P2:   if (mac_done) state_nxt = last_ax ? ST_DONE : ST_P1;
      ST_DONE: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_DONE: out_load  = !out_valid_r || out_tready;
      default: ;
    endcase
    start_nxt = is_op(state_nxt) && (state_nxt != state_r);
  end

  always_comb begin
    mac_opa            = '0;
    mac_opb            = '0;
    mac_coef           = '0;
    mac_base           = pos_r[ax_r];
    mac_cmd.start      = start_r;
    mac_cmd.gain_scale = 1'b0;
    case (state_r)
      ST_KS: begin
        mac_opa  = MW'(dt_r);
        mac_coef = COEF_W'(spring_r);
      end
      ST_KD: begin
        mac_opa  = MW'(dt_r);
        mac_coef = COEF_W'(damping_r);
      end
      ST_P1: begin
        mac_opa  = MW'(vel_r[ax_r]);
        mac_coef = COEF_W'(dt_r);
      end
      ST_V1: begin
        mac_opa            = MW'(tgt_r[ax_r]);
        mac_opb            = MW'(pos_r[ax_r]);
        mac_coef           = ks_r;
        mac_base           = vel_r[ax_r];
        mac_cmd.gain_scale = 1'b1;
      end
      ST_V2: begin
        mac_opa            = MW'(spd_r[ax_r]);
        mac_opb            = MW'(vel_r[ax_r]);
        mac_coef           = kd_r;
        mac_base           = vel_r[ax_r];
        mac_cmd.gain_scale = 1'b1;
      end
      ST_P2: begin
        mac_opa  = MW'(vel_r[ax_r]);
        mac_coef = COEF_W'(dt_r);
        mac_base = p1_r;
      end
      default: ;
    endcase
  end

  sdpt_mac #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (mac_cmd),
    .opa    (mac_opa),
    .opb    (mac_opb),
    .coef   (mac_coef),
    .base   (mac_base),
    .done   (mac_done),
    .result (mac_res),
    .raw    (mac_raw)
  );

  for (genvar g = 0; g < MAX_AXES; g++) begin : g_out
    if (g < AXES) begin : g_used
      assign out_data_nxt[FIELD_W*g +: FIELD_W]           = FIELD_W'(pos_r[g]);
      assign out_data_nxt[VEL_LSB + FIELD_W*g +: FIELD_W] = FIELD_W'(vel_r[g]);
    end else begin : g_unused
      assign out_data_nxt[FIELD_W*g +: FIELD_W]           = '0;
      assign out_data_nxt[VEL_LSB + FIELD_W*g +: FIELD_W] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= 1'b0;
      ax_r        <= '0;
      out_valid_r <= 1'b0;
      spring_r    <= SPRING_RST;
      damping_r   <= DAMPING_RST;
      linear_r    <= 1'b1;
      active_r    <= 1'b1;
      for (int i = 0; i < AXES; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
      if (in_acc) begin
        ax_r <= '0;
      end else if (state_r == ST_P2 && mac_done && !last_ax) begin
        ax_r <= ax_r + AW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SPRING:  spring_r  <= cfg_data;
          CFG_DAMPING: damping_r <= cfg_data;
          CFG_LINEAR:  linear_r  <= cfg_data[0];
          CFG_ACTIVE:  active_r  <= cfg_data[0];
          default: ;
        endcase
      end
      if (mac_done) begin
        case (state_r)
          ST_V1, ST_V2: vel_r[ax_r] <= mac_res;
          ST_P2:        pos_r[ax_r] <= mac_res;
          default: ;
        endcase
      end
      if (state_r == ST_LOAD) begin
        for (int i = 0; i < AXES; i++) begin
          case (req_r)
            REQ_INIT: begin
              pos_r[i] <= sat_v(EW'(tgt_r[i]));
              vel_r[i] <= sat_v(EW'(spd_r[i]));
            end
            REQ_IMPULSE: vel_r[i] <= sat_v(EW'(vel_r[i]) + EW'(spd_r[i]));
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < AXES; i++) begin
        tgt_r[i] <= in_tdata[FIELD_W*i +: FIELD_W];
        spd_r[i] <= in_tdata[SPD_LSB + FIELD_W*i +: FIELD_W];
      end
      dt_r  <= in_tdata[DT_LSB +: DT_W];
      req_r <= in_tuser;
    end
    if (mac_done) begin
      case (state_r)
        ST_KS:   ks_r <= mac_raw;
        ST_KD:   kd_r <= mac_raw;
        ST_P1:   p1_r <= mac_res;
        default: ;
      endcase
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_start_in_op: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> (state_r == ST_KS || state_r == ST_KD || state_r == ST_P1 ||
                 state_r == ST_V1 || state_r == ST_V2 || state_r == ST_P2))
    else $error("multiply start outside an arithmetic step");

  a_done_in_op: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> (state_r == ST_KS || state_r == ST_KD || state_r == ST_P1 ||
                  state_r == ST_V1 || state_r == ST_V2 || state_r == ST_P2))
    else $error("multiply result with no step waiting for it");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE && !in_tready))
    else $error("sequencer still idle after taking a request");

  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    ax_r <= AW'(AXES - 1))
    else $error("axis counter beyond last axis");

endmodule

>>> sv/sdpt_mac.sv
module sdpt_mac
  import sdpt_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  localparam int MW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mac_cmd_t                      cmd,
  input  logic signed [MW-1:0]          opa,
  input  logic signed [MW-1:0]          opb,
  input  logic        [COEF_W-1:0]      coef,
  input  logic signed [VALUE_WIDTH-1:0] base,
  output logic                          done,
  output logic signed [VALUE_WIDTH-1:0] result,
  output logic        [COEF_W-1:0]      raw
);

  localparam int  DW     = MW + 1;
  localparam int  PW     = MW + COEF_W;
  localparam int  SW     = PW + 2;
  localparam int  XW     = 96;
  localparam bit  HAS_HI = (VALUE_WIDTH > 32);
  localparam logic signed [SW-1:0] VMAX =
    SW'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] VMIN = -VMAX - SW'(1);

  mac_phase_t                   phase_r, phase_nxt;
  logic signed [DW-1:0]         diff_r;
  logic        [COEF_W-1:0]     coef_r;
  logic signed [VALUE_WIDTH-1:0] base_r;
  logic                         scale_r;
  logic                         neg_r;
  logic        [MW-1:0]         mag_r;
  logic        [63:0]           plo_r;
  logic        [63:0]           phi_r;
  logic        [PW-1:0]         rnd_r;

  logic        [63:0]           mag64;
  logic        [31:0]           mul_a;
  logic        [63:0]           mul_p;
  logic                         use_hi;
  logic        [XW-1:0]         sum_w;
  logic        [XW-1:0]         shf_w;
  logic signed [SW-1:0]         basex;
  logic signed [SW-1:0]         magx;
  logic signed [SW-1:0]         acc_w;

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      MP_IDLE: if (cmd.start) phase_nxt = MP_ABS;
      MP_ABS:  phase_nxt = MP_LO;
      MP_LO:   phase_nxt = HAS_HI ? MP_HI : MP_RND;
      MP_HI:   phase_nxt = MP_RND;
      MP_RND:  phase_nxt = MP_ACC;
      MP_ACC:  phase_nxt = MP_IDLE;
      default: phase_nxt = MP_IDLE;
    endcase
  end

  always_comb begin
    done   = 1'b0;
    use_hi = 1'b0;
    unique case (phase_r)
      MP_HI:   use_hi = 1'b1;
      MP_ACC:  done   = 1'b1;
      default: ;
    endcase
  end

  assign mag64 = 64'(mag_r);
  assign mul_a = use_hi ? mag64[63:32] : mag64[31:0];
  assign mul_p = 64'(mul_a) * 64'(coef_r);

  assign sum_w = XW'(plo_r) + (XW'(phi_r) << 32) +
                 (scale_r ? (XW'(1) << (GAIN_SHIFT - 1)) : (XW'(1) << (DT_SHIFT - 1)));
  assign shf_w = scale_r ? (sum_w >> GAIN_SHIFT) : (sum_w >> DT_SHIFT);

  assign basex = SW'(base_r);
  assign magx  = $signed(SW'(rnd_r));
  assign acc_w = neg_r ? (basex - magx) : (basex + magx);

  always_comb begin
    if (acc_w > VMAX) begin
      result = VMAX[VALUE_WIDTH-1:0];
    end else if (acc_w < VMIN) begin
      result = VMIN[VALUE_WIDTH-1:0];
    end else begin
      result = acc_w[VALUE_WIDTH-1:0];
    end
  end

  assign raw = plo_r[COEF_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= MP_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (phase_r)
      MP_IDLE: begin
        if (cmd.start) begin
          diff_r  <= DW'(opa) - DW'(opb);
          coef_r  <= coef;
          base_r  <= base;
          scale_r <= cmd.gain_scale;
          phi_r   <= '0;
        end
      end
      MP_ABS: begin
        neg_r <= diff_r[DW-1];
        mag_r <= diff_r[DW-1] ? MW'(-diff_r) : MW'(diff_r);
      end
      MP_LO:   plo_r <= mul_p;
      MP_HI:   phi_r <= mul_p;
      MP_RND:  rnd_r <= shf_w[PW-1:0];
      default: ;
    endcase
  end

endmodule

>>> tb/spring_damper_position_tracker_tb.sv
`timescale 1ns / 1ps

module spring_damper_position_tracker_tb;
  import sdpt_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int IDLE_PCT       = 27;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_AT        = 120;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 100;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [FIELD_W-1:0] Q_TOP    = 32'h7FFF_FFFF;
  localparam logic [FIELD_W-1:0] Q_BOTTOM = 32'h8000_0000;
  localparam logic [FIELD_W-1:0] Q_ONE    = 32'h0001_0000;

  typedef logic signed [63:0] wide_t;

  localparam wide_t Q_MAX = 64'sd2147483647;
  localparam wide_t Q_MIN = -64'sd2147483648;

  class track_scoreboard;
    logic [GAIN_W-1:0]     spring_k;
    logic [GAIN_W-1:0]     damping_k;
    logic                  linear_on;
    logic                  active_on;
    wide_t                 pos_q[MAX_AXES];
    wide_t                 vel_q[MAX_AXES];
    logic [OUT_DATA_W-1:0] expected_states[$];
    string                 labels[2*MAX_AXES];
    int                    mismatches;

    function new();
      int i;
      spring_k   = SPRING_RST;
      damping_k  = DAMPING_RST;
      linear_on  = 1'b1;
      active_on  = 1'b1;
      mismatches = 0;
      labels     = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z"};
      for (i = 0; i < MAX_AXES; i++) begin
        pos_q[i] = '0;
        vel_q[i] = '0;
      end
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SPRING:  spring_k  = val;
        CFG_DAMPING: damping_k = val;
        CFG_LINEAR:  linear_on = val[0];
        CFG_ACTIVE:  active_on = val[0];
        default: ;
      endcase
    endfunction

    function wide_t clamp_q16(input wide_t v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
    endfunction

    // round (a * coef) >> sh to nearest, ties away from zero
    function wide_t scale_round(input wide_t a, input logic [31:0] coef, input int sh);
      logic [63:0]  mag;
      logic [127:0] prod;
      mag  = a[63] ? -a : a;
      prod = ({64'd0, mag} * {96'd0, coef} + (128'd1 << (sh - 1))) >> sh;
      return a[63] ? -wide_t'(prod[63:0]) : wide_t'(prod[63:0]);
    endfunction

    function void note_request(input logic [REQ_W-1:0] req,
                               input logic [IN_DATA_W-1:0] data);
      logic [DT_W-1:0]       dt;
      logic [31:0]           ks;
      logic [31:0]           kd;
      wide_t                 tgt;
      wide_t                 spd;
      wide_t                 p;
      wide_t                 v;
      wide_t                 d;
      logic [OUT_DATA_W-1:0] state_beat;
      int                    i;
      dt = data[DT_LSB +: DT_W];
      ks = 32'(dt) * 32'(spring_k);
      kd = 32'(dt) * 32'(damping_k);
      if (linear_on && active_on) begin
        for (i = 0; i < MAX_AXES; i++) begin
          tgt = $signed(data[i*FIELD_W +: FIELD_W]);
          spd = $signed(data[SPD_LSB + i*FIELD_W +: FIELD_W]);
          p   = pos_q[i];
          v   = vel_q[i];
          case (req)
            REQ_UPDATE: begin
              d = tgt - p;
              p = clamp_q16(p + scale_round(v, 32'(dt), DT_SHIFT));
              v = clamp_q16(v + scale_round(d, ks, GAIN_SHIFT));
              d = spd - v;
              v = clamp_q16(v + scale_round(d, kd, GAIN_SHIFT));
              p = clamp_q16(p + scale_round(v, 32'(dt), DT_SHIFT));
            end
            REQ_INIT: begin
              p = clamp_q16(tgt);
              v = clamp_q16(spd);
            end
            REQ_IMPULSE: begin
              v = clamp_q16(v + spd);
            end
            default: ;
          endcase
          pos_q[i] = p;
          vel_q[i] = v;
        end
      end
      for (i = 0; i < MAX_AXES; i++) begin
        state_beat[i*FIELD_W +: FIELD_W]           = pos_q[i][31:0];
        state_beat[VEL_LSB + i*FIELD_W +: FIELD_W] = vel_q[i][31:0];
      end
      expected_states.push_back(state_beat);
    endfunction

    function void check_state_beat(input logic [OUT_DATA_W-1:0] data);
      logic [OUT_DATA_W-1:0] want;
      int                    k;
      if (expected_states.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected state beat: got %h", data);
        mismatches++;
        return;
      end
      want = expected_states.pop_front();
      for (k = 0; k < 2*MAX_AXES; k++) begin
        if (data[k*FIELD_W +: FIELD_W] !== want[k*FIELD_W +: FIELD_W]) begin
          if (mismatches < REPORT_LIMIT)
            $display("%s: expected %h got %h", labels[k],
                     want[k*FIELD_W +: FIELD_W], data[k*FIELD_W +: FIELD_W]);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_states.size();
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [REQ_W-1:0]      in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  bit              gaps_on      = 1'b1;
  int              results_seen = 0;
  int              hold_left    = 0;
  int              idle_cycles  = 0;
  track_scoreboard sb           = new();

  spring_damper_position_tracker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // result side: check, then hold off once for a long stretch
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_state_beat(out_tdata);
      results_seen++;
      if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("spring_damper_position_tracker: mismatch");
    $finish;
  end

  function automatic logic [IN_DATA_W-1:0] make_beat(
    input logic [FIELD_W-1:0] tx, ty, tz, sx, sy, sz,
    input logic [DT_W-1:0] dt
  );
    return {dt, sz, sy, sx, tz, ty, tx};
  endfunction

  function automatic logic [FIELD_W-1:0] rand_q16();
    case ($urandom_range(9))
      0: return $urandom;
      1: begin
        case ($urandom_range(3))
          0: return Q_TOP;
          1: return Q_BOTTOM;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $signed($urandom) >>> $urandom_range(16, 6);
    endcase
  endfunction

  function automatic logic [DT_W-1:0] rand_dt();
    case ($urandom_range(9))
      0: return DT_W'($urandom);
      1: return $urandom_range(1) ? '1 : '0;
      default: return DT_W'($urandom_range(4096));
    endcase
  endfunction

  function automatic logic [REQ_W-1:0] rand_req();
    int r;
    r = $urandom_range(99);
    if (r < 60) return REQ_UPDATE;
    if (r < 75) return REQ_INIT;
    if (r < 90) return REQ_IMPULSE;
    return REQ_UNUSED;
  endfunction

  function automatic logic [IN_DATA_W-1:0] rand_beat();
    return make_beat(rand_q16(), rand_q16(), rand_q16(),
                     rand_q16(), rand_q16(), rand_q16(), rand_dt());
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] req,
                              input logic [IN_DATA_W-1:0] data);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(req, data);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [GAIN_W-1:0] spring, damping,
                              input logic lin, act);
    logic [CFG_IDX_W-1:0]  idx[4];
    logic [CFG_DATA_W-1:0] val[4];
    int                    r;
    idx = '{CFG_SPRING, CFG_DAMPING, CFG_LINEAR, CFG_ACTIVE};
    val = '{spring, damping, {15'($urandom), lin}, {15'($urandom), act}};
    for (r = 0; r < 4; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[r];
      cfg_data  <= val[r];
      @(posedge clk);
      sb.write_reg(idx[r], val[r]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [GAIN_W-1:0] spring, damping,
                           input logic lin, act, input int count, input bit gaps);
    int n;
    program_regs(spring, damping, lin, act);
    gaps_on = gaps;
    for (n = 0; n < count; n++) send_request(rand_req(), rand_beat());
    drain();
  endtask

  initial begin
    int n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(REQ_INIT, make_beat(Q_TOP, Q_BOTTOM, '0, Q_BOTTOM, Q_TOP, Q_ONE, rand_dt()));
    send_request(REQ_UPDATE, make_beat($urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom, '0));
    send_request(REQ_UPDATE, make_beat(Q_BOTTOM, Q_TOP, '0, Q_TOP, Q_BOTTOM, -Q_ONE, '1));
    send_request(REQ_IMPULSE, make_beat('0, '0, '0, Q_TOP, Q_TOP, Q_TOP, '0));
    send_request(REQ_IMPULSE, make_beat('0, '0, '0, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM, '0));
    send_request(REQ_IMPULSE, make_beat('0, '0, '0, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM, '0));
    send_request(REQ_UNUSED, '1);
    send_request(REQ_INIT, '0);
    for (n = 0; n < 5; n++)
      send_request(REQ_UPDATE, make_beat(32'h000A_0000, 32'hFFFB_0000, 32'h0002_8000,
                                         Q_ONE, '0, -Q_ONE, 16'd1092));
    send_request(REQ_UPDATE, make_beat(Q_ONE, Q_ONE, Q_ONE, '0, '0, '0, 16'd1));
    send_request(REQ_IMPULSE, make_beat('0, '0, '0, 32'h0000_8000, 32'hFFFF_8000,
                                        32'd1, '0));
    send_request(REQ_UPDATE, '1);
    send_request(REQ_UPDATE, '0);
    send_request(REQ_INIT, make_beat(Q_TOP, Q_BOTTOM, Q_TOP, Q_TOP, Q_BOTTOM, '0, '0));
    send_request(REQ_UPDATE, make_beat(Q_BOTTOM, Q_TOP, Q_BOTTOM, Q_BOTTOM, Q_TOP, '0, '1));
    send_request(REQ_UPDATE, make_beat(Q_BOTTOM, Q_TOP, '1, '0, '0, Q_TOP, 16'h8000));
    drain();

    run_phase(SPRING_RST, DAMPING_RST, 1'b1, 1'b1, 160, 1'b1);
    run_phase('0, '0, 1'b1, 1'b1, 60, 1'b1);
    run_phase('1, '1, 1'b1, 1'b1, 60, 1'b1);
    run_phase(GAIN_W'($urandom), GAIN_W'($urandom), 1'b0, 1'b1, 30, 1'b1);
    run_phase(GAIN_W'($urandom), GAIN_W'($urandom), 1'b1, 1'b0, 30, 1'b1);
    run_phase(SPRING_RST, DAMPING_RST, 1'b1, 1'b1, 150, 1'b0);
    run_phase(GAIN_W'($urandom), GAIN_W'($urandom), 1'b1, 1'b1, 140, 1'b1);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("spring_damper_position_tracker: match");
    else
      $display("spring_damper_position_tracker: mismatch");
    $finish;
  end

endmodule
